>>> design/dtq_pkg.sv
// Shared types and constants for the drop-tail queue with congestion feedback.
// No dependencies; every other file of the block depends on this package.
`timescale 1ns / 1ps

package dtq_pkg;

  localparam int DATA_DEPTH     = 256;
  localparam int FEEDBACK_DEPTH = 8;

  localparam int LIMIT_W = 9;
  localparam int TAG_W   = 16;
  localparam int DUR_W   = 16;
  localparam int MULT_W  = 8;
  localparam int OCC_W   = 9;
  localparam int ACTR_W  = 9;

  localparam int DCNT_W = $clog2(DATA_DEPTH + 1);
  localparam int FCNT_W = $clog2(FEEDBACK_DEPTH + 1);
  localparam int CMP_W  = (DCNT_W > LIMIT_W) ? DCNT_W : LIMIT_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(200);
  localparam logic [ACTR_W-1:0]  ACTR_MAX    = '1;
  localparam logic [MULT_W-1:0]  MULT_MAX    = '1;
  localparam logic [MULT_W-1:0]  MULT_MIN    = MULT_W'(1);

  typedef enum logic [0:0] {
    OP_ARRIVAL     = 1'b0,
    OP_SERVICE_END = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    EV_QUEUED   = 3'd0,
    EV_DROPPED  = 3'd1,
    EV_DATA     = 3'd2,
    EV_FEEDBACK = 3'd3,
    EV_NONE     = 3'd4
  } event_kind_e;

  typedef struct packed {
    logic [DUR_W-1:0] duration;
    logic [TAG_W-1:0] tag;
  } data_t;

  typedef struct packed {
    event_kind_e       event_kind;
    logic [TAG_W-1:0]  sent_tag;
    logic [DUR_W-1:0]  service_duration;
    logic [MULT_W-1:0] feedback_value;
    logic              start_service;
    logic [OCC_W-1:0]  occupancy;
  } result_t;

  // Per-cell control shared by both queue chains
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

>>> design/dtq_in_if.sv
// Request channel into the block: packet arrivals and service-end events.
// Depends on dtq_pkg.
`timescale 1ns / 1ps

interface dtq_in_if;
  logic                       valid;
  logic                       ready;
  dtq_pkg::opcode_e           opcode;
  logic [dtq_pkg::TAG_W-1:0]  packet_tag;
  logic [dtq_pkg::DUR_W-1:0]  packet_duration;

  modport source (output valid, output opcode, output packet_tag,
                  output packet_duration, input ready);
  modport sink   (input valid, input opcode, input packet_tag,
                  input packet_duration, output ready);
endinterface

>>> design/dtq_out_if.sv
// Result channel out of the block: one result request per input request.
// Depends on dtq_pkg.
`timescale 1ns / 1ps

interface dtq_out_if;
  logic                        valid;
  logic                        ready;
  dtq_pkg::event_kind_e        event_kind;
  logic [dtq_pkg::TAG_W-1:0]   sent_tag;
  logic [dtq_pkg::DUR_W-1:0]   service_duration;
  logic [dtq_pkg::MULT_W-1:0]  feedback_value;
  logic                        start_service;
  logic [dtq_pkg::OCC_W-1:0]   occupancy;

  modport source (output valid, output event_kind, output sent_tag,
                  output service_duration, output feedback_value,
                  output start_service, output occupancy, input ready);
  modport sink   (input valid, input event_kind, input sent_tag,
                  input service_duration, input feedback_value,
                  input start_service, input occupancy, output ready);
endinterface

>>> design/dtq_data_cell.sv
// One slot of the packet queue chain: loads a new packet or takes its
// neighbour's packet on a pop. Depends on dtq_pkg.
`timescale 1ns / 1ps

module dtq_data_cell (
  input  logic                clk_i,
  input  dtq_pkg::cell_ctrl_t ctrl_i,
  input  dtq_pkg::data_t      fill_i,
  input  dtq_pkg::data_t      next_i,
  output dtq_pkg::data_t      q_o
);
  import dtq_pkg::*;

  data_t slot_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      slot_q <= fill_i;
    end else if (ctrl_i.shift) begin
      slot_q <= next_i;
    end
  end

  assign q_o = slot_q;
endmodule

>>> design/dtq_fb_cell.sv
// One slot of the feedback queue chain: holds a multiplier value and
// advances towards the head on a pop. Depends on dtq_pkg.
`timescale 1ns / 1ps

module dtq_fb_cell (
  input  logic                        clk_i,
  input  dtq_pkg::cell_ctrl_t         ctrl_i,
  input  logic [dtq_pkg::MULT_W-1:0]  fill_i,
  input  logic [dtq_pkg::MULT_W-1:0]  next_i,
  output logic [dtq_pkg::MULT_W-1:0]  q_o
);
  import dtq_pkg::*;

  logic [MULT_W-1:0] value_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      value_q <= fill_i;
    end else if (ctrl_i.shift) begin
      value_q <= next_i;
    end
  end

  assign q_o = value_q;
endmodule

>>> design/drop_tail_queue_with_feedback_core.sv
// Top level of the drop-tail packet queue with congestion feedback.
// Depends on dtq_pkg, dtq_in_if, dtq_out_if, dtq_data_cell and dtq_fb_cell.
//
//   port          dir   handshake       carries
//   in_i          sink  valid / ready   opcode, packet_tag, packet_duration
//   out_o         src   valid / ready   event_kind .. occupancy
//   cfg_we_i/..   in    write enable    buffer_limit (9 bits)
//
// The queue update and the result are settled in the cycle the request is
// accepted, and the result appears in the output register on the next
// cycle. A new request is taken every cycle, also while a result waits, as
// long as the output register is empty or being drained.
// Reset (rst_ni low, asynchronous) empties both queues, idles the server,
// sets the multiplier to one and buffer_limit to 200; no clearing pass.
// A stalled output holds the result and blocks the input.
`timescale 1ns / 1ps

module drop_tail_queue_with_feedback_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dtq_pkg::LIMIT_W-1:0]   cfg_wdata_i,
  dtq_in_if.sink                        in_i,
  dtq_out_if.source                     out_o
);
  import dtq_pkg::*;

  // ---------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------
  logic [LIMIT_W-1:0] limit_q;
  logic [DCNT_W-1:0]  dcnt_q, dcnt_d;
  logic [FCNT_W-1:0]  fcnt_q, fcnt_d;
  logic [ACTR_W-1:0]  actr_q, actr_d;
  logic [MULT_W-1:0]  mult_q, mult_d;
  logic               busy_q, busy_d;
  logic               out_valid_q;
  result_t            res_q, res_d;

  logic accept;
  logic data_push, data_pop, fb_push, fb_pop;

  // Cells of the two chains: cell 0 always holds the oldest entry
  data_t             data_cell_q [DATA_DEPTH];
  logic [MULT_W-1:0] fb_cell_q   [FEEDBACK_DEPTH];
  data_t             fill_data;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign fill_data.tag      = in_i.packet_tag;
  assign fill_data.duration = in_i.packet_duration;

  // ---------------------------------------------------------------------
  // Step logic: one arrival or one service end
  // ---------------------------------------------------------------------
  logic [ACTR_W-1:0] actr_inc;
  logic [DCNT_W-1:0] dcnt_plus;
  logic              drop;
  logic              crossed;
  logic              half_full;

  always_comb begin
    actr_inc  = (actr_q != ACTR_MAX) ? actr_q + ACTR_W'(1) : actr_q;
    dcnt_plus = dcnt_q + DCNT_W'(1);
    // Drop when the programmed limit is reached or the chain is physically full
    drop      = (CMP_W'(dcnt_q) >= CMP_W'(limit_q)) ||
                (CMP_W'(dcnt_q) >= CMP_W'(DATA_DEPTH));
    crossed   = actr_inc > (limit_q >> 2);
    half_full = CMP_W'(dcnt_plus) >= CMP_W'(limit_q >> 1);

    dcnt_d    = dcnt_q;
    fcnt_d    = fcnt_q;
    actr_d    = actr_q;
    mult_d    = mult_q;
    busy_d    = busy_q;
    data_push = 1'b0;
    data_pop  = 1'b0;
    fb_push   = 1'b0;
    fb_pop    = 1'b0;

    res_d                  = '0;
    res_d.event_kind       = EV_QUEUED;

    case (in_i.opcode)
      OP_SERVICE_END: begin
        // Feedback goes first, then data, else the server falls idle
        if (fcnt_q != '0) begin
          fb_pop               = 1'b1;
          fcnt_d               = fcnt_q - FCNT_W'(1);
          res_d.event_kind     = EV_FEEDBACK;
          res_d.feedback_value = fb_cell_q[0];
          busy_d               = 1'b1;
        end else if (dcnt_q != '0) begin
          data_pop               = 1'b1;
          dcnt_d                 = dcnt_q - DCNT_W'(1);
          res_d.event_kind       = EV_DATA;
          res_d.sent_tag         = data_cell_q[0].tag;
          res_d.service_duration = data_cell_q[0].duration;
          busy_d                 = 1'b1;
        end else begin
          res_d.event_kind = EV_NONE;
          busy_d           = 1'b0;
        end
      end
      OP_ARRIVAL: begin
        actr_d = actr_inc;
        if (drop) begin
          res_d.event_kind = EV_DROPPED;
        end else begin
          data_push        = 1'b1;
          dcnt_d           = dcnt_plus;
          res_d.event_kind = EV_QUEUED;
          if (crossed) begin
            actr_d = '0;
            if (half_full) begin
              // Raise the multiplier, saturating, and report it if the feedback queue has room
              mult_d  = (mult_q != MULT_MAX) ? mult_q + MULT_W'(1) : mult_q;
              fb_push = (CMP_W'(fcnt_q) < CMP_W'(FEEDBACK_DEPTH));
            end else if (mult_q > MULT_MIN) begin
              mult_d  = mult_q - MULT_W'(1);
              fb_push = (CMP_W'(fcnt_q) < CMP_W'(FEEDBACK_DEPTH));
            end
          end
          if (fb_push) begin
            fcnt_d = fcnt_q + FCNT_W'(1);
          end
          if (!busy_q) begin
            res_d.start_service = 1'b1;
            busy_d              = 1'b1;
          end
        end
      end
      default: begin
        res_d.event_kind = EV_NONE;
      end
    endcase

    res_d.occupancy = OCC_W'(dcnt_d);
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LIMIT_RESET;
      dcnt_q      <= '0;
      fcnt_q      <= '0;
      actr_q      <= '0;
      mult_q      <= MULT_MIN;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (accept) begin
        dcnt_q      <= dcnt_d;
        fcnt_q      <= fcnt_d;
        actr_q      <= actr_d;
        mult_q      <= mult_d;
        busy_q      <= busy_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: no reset, qualified by out_valid_q
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  // ---------------------------------------------------------------------
  // Packet chain: a push loads the cell just past the tail, a pop advances
  // every cell one place towards the head
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < DATA_DEPTH; i++) begin : g_data
    cell_ctrl_t ctrl;
    data_t      next;

    assign ctrl.load  = accept && data_push && (dcnt_q == DCNT_W'(i));
    assign ctrl.shift = accept && data_pop;

    if (i == DATA_DEPTH - 1) begin : g_last
      assign next = data_cell_q[i];
    end else begin : g_mid
      assign next = data_cell_q[i+1];
    end

    dtq_data_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .fill_i (fill_data),
      .next_i (next),
      .q_o    (data_cell_q[i])
    );
  end

  // ---------------------------------------------------------------------
  // Feedback chain: same scheme, carrying the new multiplier value
  // ---------------------------------------------------------------------
  for (genvar j = 0; j < FEEDBACK_DEPTH; j++) begin : g_fb
    cell_ctrl_t        ctrl;
    logic [MULT_W-1:0] next;

    assign ctrl.load  = accept && fb_push && (fcnt_q == FCNT_W'(j));
    assign ctrl.shift = accept && fb_pop;

    if (j == FEEDBACK_DEPTH - 1) begin : g_last
      assign next = fb_cell_q[j];
    end else begin : g_mid
      assign next = fb_cell_q[j+1];
    end

    dtq_fb_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .fill_i (mult_d),
      .next_i (next),
      .q_o    (fb_cell_q[j])
    );
  end

  // ---------------------------------------------------------------------
  // Output channel
  // ---------------------------------------------------------------------
  assign out_o.valid            = out_valid_q;
  assign out_o.event_kind       = res_q.event_kind;
  assign out_o.sent_tag         = res_q.sent_tag;
  assign out_o.service_duration = res_q.service_duration;
  assign out_o.feedback_value   = res_q.feedback_value;
  assign out_o.start_service    = res_q.start_service;
  assign out_o.occupancy        = res_q.occupancy;

endmodule
